[rtl/rle_dec_pkg.sv]
`timescale 1ns / 1ps

package rle_dec_pkg;

   localparam logic [2:0] MAX_PIXEL_BYTES   = 3'd4;
   localparam logic [1:0] PIXELS_PER_RESULT = 2'd2;
   localparam logic [7:0] COUNT_MASK        = 8'h7F;
   localparam logic [7:0] RUN_FLAG          = 8'h80;

   localparam logic [1:0] CSR_PIXEL_BYTES = 2'd0;
   localparam logic [1:0] CSR_PIXEL_TOTAL = 2'd1;

   // one completed pixel value with its clipped repeat count
   typedef struct packed {
      logic        valid;
      logic [31:0] value;
      logic [7:0]  count;
      logic        image_end;
   } job_type;

endpackage

[rtl/rle_dec_front.sv]
`timescale 1ns / 1ps

module rle_dec_front import rle_dec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        job_ready,
   output job_type     job
);

   logic [2:0]  pixel_bytes_ff, pixel_bytes_in;
   logic [29:0] pixel_total_ff, pixel_total_in;
   logic        expect_header_ff, expect_header_in;
   logic        run_packet_ff, run_packet_in;
   logic [7:0]  pixels_left_ff, pixels_left_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [29:0] pixels_done_ff, pixels_done_in;
   logic        finished_ff, finished_in;

   logic        accept;
   logic [2:0]  eff_bytes;
   logic [1:0]  pos_next;
   logic [31:0] value_done;
   logic        complete;
   logic [7:0]  want;
   logic [29:0] room;
   logic [7:0]  n_clip;
   logic [29:0] done_sum;
   logic [7:0]  left_next;

   assign csr_ready = 1'b1;
   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;

   always_comb begin
      if (pixel_bytes_ff == 3'd0) begin
         eff_bytes = 3'd1;
      end else if (pixel_bytes_ff > MAX_PIXEL_BYTES) begin
         eff_bytes = MAX_PIXEL_BYTES;
      end else begin
         eff_bytes = pixel_bytes_ff;
      end
   end

   assign pos_next   = byte_pos_ff + 2'd1;
   assign value_done = assembly_ff | ({24'd0, req_data_byte} << {byte_pos_ff, 3'b000});
   assign complete   = (pos_next == 2'd0) || ({1'b0, pos_next} >= eff_bytes);
   assign want       = run_packet_ff ? pixels_left_ff : 8'd1;
   assign room       = (pixel_total_ff > pixels_done_ff) ? (pixel_total_ff - pixels_done_ff)
                                                         : 30'd0;
   assign n_clip     = (room < {22'd0, want}) ? room[7:0] : want;
   assign done_sum   = pixels_done_ff + {22'd0, n_clip};
   assign left_next  = run_packet_ff ? 8'd0
                     : ((pixels_left_ff != 8'd0) ? (pixels_left_ff - 8'd1) : 8'd0);

   always_comb begin
      pixel_bytes_in   = pixel_bytes_ff;
      pixel_total_in   = pixel_total_ff;
      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      pixels_left_in   = pixels_left_ff;
      byte_pos_in      = byte_pos_ff;
      assembly_in      = assembly_ff;
      pixels_done_in   = pixels_done_ff;
      finished_in      = finished_ff;
      job.valid        = 1'b0;
      job.value        = value_done;
      job.count        = n_clip;
      job.image_end    = (done_sum >= pixel_total_ff);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_PIXEL_BYTES: pixel_bytes_in = csr_data[2:0];
            CSR_PIXEL_TOTAL: pixel_total_in = csr_data[29:0];
            default: ;
         endcase
      end

      if (accept && !finished_ff) begin
         if (expect_header_ff) begin
            run_packet_in    = (req_data_byte & RUN_FLAG) != 8'd0;
            pixels_left_in   = (req_data_byte & COUNT_MASK) + 8'd1;
            byte_pos_in      = 2'd0;
            assembly_in      = 32'd0;
            expect_header_in = 1'b0;
         end else if (!complete) begin
            assembly_in = value_done;
            byte_pos_in = pos_next;
         end else begin
            job.valid        = (n_clip != 8'd0);
            pixels_done_in   = done_sum;
            finished_in      = (done_sum >= pixel_total_ff);
            pixels_left_in   = left_next;
            byte_pos_in      = 2'd0;
            assembly_in      = 32'd0;
            expect_header_in = (left_next == 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff   <= 3'd4;
         pixel_total_ff   <= 30'd1;
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         pixels_left_ff   <= 8'd0;
         byte_pos_ff      <= 2'd0;
         assembly_ff      <= 32'd0;
         pixels_done_ff   <= 30'd0;
         finished_ff      <= 1'b0;
      end else begin
         pixel_bytes_ff   <= pixel_bytes_in;
         pixel_total_ff   <= pixel_total_in;
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         pixels_left_ff   <= pixels_left_in;
         byte_pos_ff      <= byte_pos_in;
         assembly_ff      <= assembly_in;
         pixels_done_ff   <= pixels_done_in;
         finished_ff      <= finished_in;
      end
   end

   // finished image stays finished until reset
   a_finish_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("image finished flag dropped");

   // a job never carries more pixels than the image has room for
   a_job_fits: assert property (@(posedge clock) disable iff (reset)
      job.valid |-> ({22'd0, job.count} <= room))
      else $error("job exceeds remaining image");

endmodule

[rtl/rle_dec_emit.sv]
`timescale 1ns / 1ps

module rle_dec_emit import rle_dec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  job_type     job,
   output logic        job_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_first,
   output logic [31:0] rsp_pixel_second,
   output logic [1:0]  rsp_pair_count,
   output logic        rsp_image_end
);

   logic        job_valid_ff, job_valid_in;
   logic [31:0] job_value_ff, job_value_in;
   logic [7:0]  job_count_ff, job_count_in;
   logic        job_end_ff, job_end_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] second_ff, second_in;
   logic [1:0]  pair_ff, pair_in;
   logic        end_ff, end_in;

   logic        out_free;
   logic        move;
   logic        last;
   logic [1:0]  take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = job_valid_ff && out_free;
   assign last      = (job_count_ff <= {6'd0, PIXELS_PER_RESULT});
   assign take      = last ? job_count_ff[1:0] : PIXELS_PER_RESULT;
   assign job_ready = !job_valid_ff || (move && last);

   always_comb begin
      job_valid_in = job_valid_ff;
      job_value_in = job_value_ff;
      job_count_in = job_count_ff;
      job_end_in   = job_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      first_in     = first_ff;
      second_in    = second_ff;
      pair_in      = pair_ff;
      end_in       = end_ff;

      if (move) begin
         rsp_valid_in = 1'b1;
         first_in     = job_value_ff;
         second_in    = (take == PIXELS_PER_RESULT) ? job_value_ff : 32'd0;
         pair_in      = take;
         end_in       = last && job_end_ff;
         job_count_in = job_count_ff - {6'd0, take};
         if (last) begin
            job_valid_in = 1'b0;
         end
      end

      if (job.valid) begin
         job_valid_in = 1'b1;
         job_value_in = job.value;
         job_count_in = job.count;
         job_end_in   = job.image_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_value_ff <= job_value_in;
      job_count_ff <= job_count_in;
      job_end_ff   <= job_end_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      pair_ff      <= pair_in;
      end_ff       <= end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_first  = first_ff;
   assign rsp_pixel_second = second_ff;
   assign rsp_pair_count   = pair_ff;
   assign rsp_image_end    = end_ff;

   a_job_nonzero: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_count_ff != 8'd0))
      else $error("pending job with zero pixels");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      job.valid |-> job_ready)
      else $error("job loaded while previous job pending");

   a_single_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (pair_ff == 2'd1)) |-> (second_ff == 32'd0))
      else $error("single-pixel item carries a second pixel");

endmodule

[rtl/rle_image_packet_decoder.sv]
`timescale 1ns / 1ps

// Run-length image packet decoder. Takes one packet byte per item on req_ and returns
// decoded pixels on rsp_, up to two per item, with rsp_image_end on the item holding the
// image's last pixel. Header bytes and partial pixel bytes produce nothing; raw packets
// give one single-pixel item per completed value; a run of N pixels gives ceil(N/2) items.
// A byte is taken every cycle as long as the job register can drain: it holds one
// completed value and its count, and a run stays in it until its last item moves out,
// with req_ready low until then (longer while rsp_ready is low). A completed value is
// registered in the job register, then in the output register. Pixels beyond
// pixel_total are dropped and later bytes are accepted and ignored until reset.
// csr_index 0 writes pixel_bytes, 1 writes pixel_total; csr_ready is always high.

module rle_image_packet_decoder import rle_dec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_first,
   output logic [31:0] rsp_pixel_second,
   output logic [1:0]  rsp_pair_count,
   output logic        rsp_image_end
);

   job_type job;
   logic    job_ready;

   rle_dec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .job_ready     (job_ready),
      .job           (job)
   );

   rle_dec_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .job              (job),
      .job_ready        (job_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pair_count   (rsp_pair_count),
      .rsp_image_end    (rsp_image_end)
   );

endmodule

[tb/rle_image_packet_decoder_tb.sv]
`timescale 1ns / 1ps

module rle_image_packet_decoder_tb;
   import rle_dec_pkg::*;

   typedef struct packed {
      logic [31:0] first_pixel;
      logic [31:0] second_pixel;
      logic [1:0]  pair_count;
      logic        image_end;
   } pixel_pair_type;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [1:0]     index;
      logic [31:0]    data;
      logic           typed;
      pixel_pair_type pair;
   } stim_row_type;

   localparam logic [1:0]  CSR_SPARE_2      = 2'd2;
   localparam logic [1:0]  CSR_SPARE_3      = 2'd3;
   localparam logic [29:0] TOTAL_MAX        = 30'h3FFF_FFFF;
   localparam int          TAIL_CYCLES      = 8;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          PHASE_ITEMS      = 65;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PIXEL_BYTES;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_first;
   logic [31:0] rsp_pixel_second;
   logic [1:0]  rsp_pair_count;
   logic        rsp_image_end;

   always #10 clock = ~clock;

   rle_image_packet_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pair_count   (rsp_pair_count),
      .rsp_image_end    (rsp_image_end)
   );

   // decoder state as seen from the byte stream
   logic [2:0]  cfg_pixel_bytes = 3'd4;
   int unsigned cfg_pixel_total = 1;
   bit          want_header = 1'b1;
   bit          in_run = 1'b0;
   int unsigned left_in_packet = 0;
   logic [1:0]  byte_pos = 2'd0;
   logic [31:0] assembly = '0;
   int unsigned pixels_done = 0;
   bit          image_done = 1'b0;
   int unsigned pushed_total = 0;

   pixel_pair_type pending_pairs[$];
   logic [7:0]     packet_bytes[$];
   stim_row_type   stim_rows[$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          long_hold_pending = 1'b0;
   int          hold_left = 0;

   function automatic int unsigned active_pixel_bytes();
      if (cfg_pixel_bytes < 3'd1) return 1;
      if (cfg_pixel_bytes > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
      return cfg_pixel_bytes;
   endfunction

   function automatic void emit_pixels(logic [31:0] value, int unsigned n);
      int unsigned room;
      int unsigned take;
      pixel_pair_type p;
      room = (cfg_pixel_total > pixels_done) ? cfg_pixel_total - pixels_done : 0;
      if (n > room) n = room;
      while (n > 0) begin
         take = (n >= PIXELS_PER_RESULT) ? PIXELS_PER_RESULT : n;
         n -= take;
         pixels_done += take;
         p.first_pixel  = value;
         p.second_pixel = (take == 2) ? value : 32'h0;
         p.pair_count   = take[1:0];
         p.image_end    = (pixels_done >= cfg_pixel_total);
         pending_pairs.push_back(p);
         pushed_total++;
      end
      if (pixels_done >= cfg_pixel_total) image_done = 1'b1;
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      if (image_done) return;
      if (want_header) begin
         in_run         = (b & RUN_FLAG) != 8'h00;
         left_in_packet = 32'(b & COUNT_MASK) + 1;
         byte_pos       = 2'd0;
         assembly       = '0;
         want_header    = 1'b0;
         return;
      end
      assembly |= 32'(b) << (8 * byte_pos);
      byte_pos = byte_pos + 2'd1;
      if (byte_pos != 2'd0 && byte_pos < active_pixel_bytes()) return;
      if (in_run) begin
         emit_pixels(assembly, left_in_packet);
         left_in_packet = 0;
      end else begin
         emit_pixels(assembly, 1);
         if (left_in_packet > 0) left_in_packet--;
      end
      byte_pos = 2'd0;
      assembly = '0;
      if (left_in_packet == 0) want_header = 1'b1;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [31:0] data);
      if (idx == CSR_PIXEL_BYTES) cfg_pixel_bytes = data[2:0];
      else if (idx == CSR_PIXEL_TOTAL) cfg_pixel_total = data[29:0];
   endfunction

   function automatic stim_row_type csr_row(logic [1:0] idx, logic [31:0] data);
      stim_row_type r;
      r = '0;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.data  = data;
      return r;
   endfunction

   function automatic stim_row_type byte_row(logic [7:0] b);
      stim_row_type r;
      r = '0;
      r.kind = ROW_BYTE;
      r.data = 32'(b);
      return r;
   endfunction

   function automatic stim_row_type pair_row(logic [7:0] b, logic [31:0] p0, logic [31:0] p1,
                                             logic [1:0] cnt, logic last);
      stim_row_type r;
      r = byte_row(b);
      r.typed = 1'b1;
      r.pair.first_pixel  = p0;
      r.pair.second_pixel = p1;
      r.pair.pair_count   = cnt;
      r.pair.image_end    = last;
      return r;
   endfunction

   // well-formed packet with random content, sometimes led by a stray byte
   function automatic void queue_packet();
      int unsigned sel;
      int unsigned cnt;
      int unsigned values;
      bit          run;
      sel = $urandom_range(0, 99);
      if (sel < 70) cnt = $urandom_range(0, 3);
      else if (sel < 90) cnt = $urandom_range(4, 15);
      else cnt = $urandom_range(0, 127);
      run = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) packet_bytes.push_back(8'($urandom_range(0, 255)));
      packet_bytes.push_back({run, cnt[6:0]});
      values = run ? 1 : cnt + 1;
      repeat (values * active_pixel_bytes())
         packet_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b);
   endtask

   task automatic send_stream(input int n);
      repeat (n) begin
         if (packet_bytes.size() == 0) queue_packet();
         send_byte(packet_bytes.pop_front());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic [2:0] pb,
                            input bit long_hold);
      logic [31:0] data;
      wait_idle();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      data = $urandom();
      data[2:0] = pb;
      write_csr(CSR_PIXEL_BYTES, data);
      data = $urandom();
      data[29:0] = TOTAL_MAX;
      write_csr(CSR_PIXEL_TOTAL, data);
      write_csr(CSR_SPARE_2, $urandom());
      write_csr(CSR_SPARE_3, $urandom());
      if (long_hold) long_hold_pending = 1'b1;
      send_stream(PHASE_ITEMS);
   endtask

   always @(posedge clock) begin
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_pair_type exp_pair;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected item: first %h second %h count %0d end %0d",
                   rsp_pixel_first, rsp_pixel_second, rsp_pair_count, rsp_image_end);
            errors++;
         end else begin
            exp_pair = pending_pairs.pop_front();
            if (rsp_pixel_first !== exp_pair.first_pixel) begin
               $error("pixel_first: expected %h, got %h", exp_pair.first_pixel,
                      rsp_pixel_first);
               errors++;
            end
            if (rsp_pixel_second !== exp_pair.second_pixel) begin
               $error("pixel_second: expected %h, got %h", exp_pair.second_pixel,
                      rsp_pixel_second);
               errors++;
            end
            if (rsp_pair_count !== exp_pair.pair_count) begin
               $error("pair_count: expected %0d, got %0d", exp_pair.pair_count,
                      rsp_pair_count);
               errors++;
            end
            if (rsp_image_end !== exp_pair.image_end) begin
               $error("image_end: expected %0d, got %0d", exp_pair.image_end,
                      rsp_image_end);
               errors++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned prev_pushed;
      logic [31:0] data;
      stim_row_type row;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stim_rows.push_back(csr_row(CSR_PIXEL_TOTAL, 32'd1));
      stim_rows.push_back(csr_row(CSR_PIXEL_TOTAL, {2'b00, TOTAL_MAX}));
      stim_rows.push_back(csr_row(CSR_PIXEL_BYTES, 32'd1));
      stim_rows.push_back(byte_row(8'h00));
      stim_rows.push_back(pair_row(8'hFF, 32'hFF, 32'h0, 2'd1, 1'b0));
      stim_rows.push_back(byte_row(8'h80));
      stim_rows.push_back(pair_row(8'h00, 32'h0, 32'h0, 2'd1, 1'b0));
      stim_rows.push_back(byte_row(8'h81));
      stim_rows.push_back(pair_row(8'hA5, 32'hA5, 32'hA5, 2'd2, 1'b0));
      stim_rows.push_back(byte_row(8'hFF));
      stim_rows.push_back(byte_row(8'h5A));
      stim_rows.push_back(byte_row(8'h02));
      stim_rows.push_back(pair_row(8'h01, 32'h01, 32'h0, 2'd1, 1'b0));
      stim_rows.push_back(pair_row(8'h80, 32'h80, 32'h0, 2'd1, 1'b0));
      stim_rows.push_back(pair_row(8'hFE, 32'hFE, 32'h0, 2'd1, 1'b0));
      stim_rows.push_back(csr_row(CSR_PIXEL_BYTES, 32'd4));
      stim_rows.push_back(byte_row(8'h80));
      stim_rows.push_back(byte_row(8'h11));
      stim_rows.push_back(byte_row(8'h22));
      stim_rows.push_back(byte_row(8'h33));
      stim_rows.push_back(pair_row(8'h44, 32'h4433_2211, 32'h0, 2'd1, 1'b0));
      // zero bytes per pixel behaves as one
      stim_rows.push_back(csr_row(CSR_PIXEL_BYTES, 32'd0));
      stim_rows.push_back(byte_row(8'h00));
      stim_rows.push_back(pair_row(8'h7E, 32'h7E, 32'h0, 2'd1, 1'b0));
      // oversize setting behaves as four
      stim_rows.push_back(csr_row(CSR_PIXEL_BYTES, 32'd7));
      stim_rows.push_back(byte_row(8'h81));
      stim_rows.push_back(byte_row(8'hFF));
      stim_rows.push_back(byte_row(8'hFF));
      stim_rows.push_back(byte_row(8'hFF));
      stim_rows.push_back(pair_row(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2, 1'b0));

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.index, row.data);
         end else begin
            prev_pushed = pushed_total;
            send_byte(row.data[7:0]);
            if (row.typed) begin
               repeat (pushed_total - prev_pushed) void'(pending_pairs.pop_back());
               pending_pairs.push_back(row.pair);
            end
         end
      end

      run_phase(0, 0, 3'd1, 1'b0);
      run_phase(59, 0, 3'd4, 1'b0);
      run_phase(0, 59, 3'd2, 1'b0);
      run_phase(29, 29, 3'd3, 1'b0);
      run_phase(0, 0, 3'($urandom_range(0, 7)), 1'b1);
      run_phase(29, 29, 3'($urandom_range(0, 7)), 1'b0);

      // shrink the image so the stream runs into its end, then feed bytes past it
      wait_idle();
      data = $urandom();
      data[29:0] = 30'(pixels_done + 1 + $urandom_range(0, 4));
      write_csr(CSR_PIXEL_TOTAL, data);
      while (!image_done) send_stream(1);
      send_stream(6);
      wait_idle();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[rle_image_packet_decoder.f]
rtl/rle_dec_pkg.sv
rtl/rle_dec_front.sv
rtl/rle_dec_emit.sv
rtl/rle_image_packet_decoder.sv
tb/rle_image_packet_decoder_tb.sv
